/* hdl/lcdw_pkg.sv */
// ----------------------------------------------------------------------------
// lcdw_pkg: shared types and constants for the character display writer
// Request and transfer beats, queued jobs and the DDRAM row map.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  localparam int unsigned DefColumns    = 20;
  localparam int unsigned DefRows       = 4;
  localparam int unsigned DefQueueDepth = 2;

  // Largest number of bus bytes one request turns into
  localparam int unsigned MaxBytes = 3;

  localparam logic [7:0]  CmdClear      = 8'h01;
  localparam logic [7:0]  CmdSetDdram   = 8'h80;
  localparam logic [7:0]  NibbleMask    = 8'hF0;
  localparam logic [10:0] WaitLongUs    = 11'd2000;
  localparam logic [10:0] WaitCmdUs     = 11'd600;
  localparam logic [10:0] WaitDataUs    = 11'd4;
  localparam logic [10:0] WaitNibbleUs  = 11'd0;

  typedef enum logic [1:0] {
    FUNC_WRITE_CHAR = 2'd0,
    FUNC_RAW_CMD    = 2'd1,
    FUNC_GOTO       = 2'd2,
    FUNC_CLEAR      = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  byte_value;
    logic [4:0]  column;
    logic [1:0]  row;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [10:0] wait_us;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        rs;
    logic [7:0]  value;
  } bus_byte_t;

  // One classified request: up to three bus bytes, count from 1 to 3
  typedef struct packed {
    logic [1:0]                     count;
    bus_byte_t [MaxBytes-1:0]       bytes;
  } job_t;

  // DDRAM base of a row; one past the last row wraps to base zero
  function automatic logic [6:0] row_base(input logic [2:0] r);
    logic [6:0] b;
    case (r)
      3'd0:    b = 7'h00;
      3'd1:    b = 7'h40;
      3'd2:    b = 7'h14;
      3'd3:    b = 7'h54;
      default: b = 7'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/lcdw_fifo.sv */
// ----------------------------------------------------------------------------
// lcdw_fifo: short job queue between front and back
// Register-based first-in first-out queue with valid/ready style flags.
// ----------------------------------------------------------------------------
module lcdw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             head_valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/lcdw_front.sv */
// ----------------------------------------------------------------------------
// lcdw_front: request intake and cursor tracking
// Accepts requests, advances the cursor and turns each request into a job.
// ----------------------------------------------------------------------------
module lcdw_front #(
  parameter int unsigned COLUMNS = lcdw_pkg::DefColumns,
  parameter int unsigned ROWS    = lcdw_pkg::DefRows
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lcdw_pkg::req_t in_req_i,
  output logic           push_o,
  output lcdw_pkg::job_t job_o,
  input  logic           queue_full_i
);

  import lcdw_pkg::*;

  logic [4:0] cursor_col_q, cursor_col_d;
  logic [1:0] cursor_row_q, cursor_row_d;
  logic       accept;
  logic       line_end;
  logic [2:0] next_row;
  logic [7:0] goto_addr;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i & ~queue_full_i;
  assign push_o     = accept;

  assign line_end  = ({1'b0, cursor_col_q} + 6'd1) >= 6'(COLUMNS);
  assign next_row  = {1'b0, cursor_row_q} + 3'd1;
  assign goto_addr = {1'b0, row_base({1'b0, in_req_i.row})} + {3'b000, in_req_i.column};

  always_comb begin
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    job_o        = '0;
    case (in_req_i.func)
      FUNC_WRITE_CHAR: begin
        job_o.bytes[0] = '{rs: 1'b1, value: in_req_i.byte_value};
        job_o.count    = 2'd1;
        if (line_end) begin
          cursor_col_d   = '0;
          job_o.bytes[1] = '{rs: 1'b0, value: CmdSetDdram | {1'b0, row_base(next_row)}};
          job_o.count    = 2'd2;
          // past the bottom: home to row zero with a second address command
          if (next_row >= 3'(ROWS)) begin
            cursor_row_d   = '0;
            job_o.bytes[2] = '{rs: 1'b0, value: CmdSetDdram};
            job_o.count    = 2'd3;
          end else begin
            cursor_row_d = next_row[1:0];
          end
        end else begin
          cursor_col_d = cursor_col_q + 5'd1;
        end
      end
      FUNC_RAW_CMD: begin
        job_o.bytes[0] = '{rs: 1'b0, value: in_req_i.byte_value};
        job_o.count    = 2'd1;
      end
      FUNC_GOTO: begin
        cursor_col_d   = in_req_i.column;
        cursor_row_d   = in_req_i.row;
        job_o.bytes[0] = '{rs: 1'b0, value: CmdSetDdram | {1'b0, goto_addr[6:0]}};
        job_o.count    = 2'd1;
      end
      default: begin
        cursor_col_d   = '0;
        cursor_row_d   = '0;
        job_o.bytes[0] = '{rs: 1'b0, value: CmdClear};
        job_o.bytes[1] = '{rs: 1'b0, value: CmdSetDdram};
        job_o.count    = 2'd2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_col_q <= '0;
      cursor_row_q <= '0;
    end else if (accept) begin
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
    end
  end

endmodule

/* hdl/lcdw_back.sv */
// ----------------------------------------------------------------------------
// lcdw_back: bus transfer sequencer
// Walks the bytes of the head job, splits them into nibbles in 4-bit mode
// and drives one beat per cycle through an output register unless stalled.
// ----------------------------------------------------------------------------
module lcdw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  lcdw_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lcdw_pkg::rsp_t out_rsp_o
);

  import lcdw_pkg::*;

  logic       four_bit_q;
  logic [1:0] idx_q, idx_d;
  logic       nib_q, nib_d;
  logic       out_valid_q, out_valid_d;
  rsp_t       rsp_q, rsp_d;
  bus_byte_t  cur;
  logic [10:0] full_wait;
  logic       load;
  logic       byte_done;
  logic       job_done;

  assign cur       = job_i.bytes[idx_q];
  assign load      = job_valid_i & (~out_valid_q | ~out_stall_i);
  assign byte_done = ~four_bit_q | nib_q;
  assign job_done  = byte_done & (idx_q == job_i.count - 2'd1);
  assign pop_o     = load & job_done;

  always_comb begin
    if (cur.rs) begin
      full_wait = WaitDataUs;
    end else if (cur.value <= CmdClear) begin
      full_wait = WaitLongUs;
    end else begin
      full_wait = WaitCmdUs;
    end
  end

  always_comb begin
    rsp_d            = rsp_q;
    rsp_d.reg_select = cur.rs;
    rsp_d.last       = job_done;
    if (!four_bit_q) begin
      rsp_d.bus_value = cur.value;
      rsp_d.wait_us   = full_wait;
    end else if (!nib_q) begin
      rsp_d.bus_value = cur.value & NibbleMask;
      rsp_d.wait_us   = WaitNibbleUs;
    end else begin
      rsp_d.bus_value = {cur.value[3:0], 4'h0};
      rsp_d.wait_us   = full_wait;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    nib_d       = nib_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      if (job_done) begin
        idx_d = '0;
        nib_d = 1'b0;
      end else if (byte_done) begin
        idx_d = idx_q + 2'd1;
        nib_d = 1'b0;
      end else begin
        nib_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q  <= 1'b1;
      idx_q       <= '0;
      nib_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        four_bit_q <= cfg_wdata_i;
      end
      idx_q       <= idx_d;
      nib_q       <= nib_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

/* hdl/char_lcd_writer_with_cursor_top.sv */
// ----------------------------------------------------------------------------
// char_lcd_writer_with_cursor_top: character display request writer
// Turns display requests into timed register-select/bus transfer beats.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per beat:
// write character, raw command, go to column and row, or clear. The front
// stage tracks the cursor and queues a job of one to three bus bytes.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): one bus transfer per
// beat with register select, D7..D0, settle wait in microseconds and a last
// flag on the final transfer of each request.
// Config: cfg_we_i writes cfg_wdata_i into the 4-bit mode flag (reset 1);
// write it only while no request is in flight.
// The first transfer of a request passes through the job queue and then the
// output register. One transfer per cycle while the receiver does not stall;
// the back sequencer makes 1 to 6 per request (bytes times nibbles per byte).
// Requests keep being taken while the job queue has room.
// Reset clears the cursor, the queue and the output valid flag; when the
// receiver stalls, the current beat holds and the queue then fills and
// stalls the input.
// ----------------------------------------------------------------------------
module char_lcd_writer_with_cursor_top #(
  parameter int unsigned COLUMNS     = lcdw_pkg::DefColumns,
  parameter int unsigned ROWS        = lcdw_pkg::DefRows,
  parameter int unsigned QUEUE_DEPTH = lcdw_pkg::DefQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lcdw_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lcdw_pkg::rsp_t out_rsp_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);

  import lcdw_pkg::*;

  logic push;
  job_t push_job;
  logic queue_full;
  logic pop;
  job_t head_job;
  logic head_valid;

  lcdw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .push_o      (push),
    .job_o       (push_job),
    .queue_full_i(queue_full)
  );

  lcdw_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_o      (head_job),
    .head_valid_o(head_valid)
  );

  lcdw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .job_i      (head_job),
    .job_valid_i(head_valid),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
